// File: design/lpht_pkg.sv
package lpht_pkg;

	// multiplicative hash: home slot from the top byte of the low 64 bits of key * HASH_MULT
	localparam logic [63:0] HASH_MULT  = 64'h9E37_79B9_7F4A_7C15;
	localparam int          HASH_SHIFT = 56;
	localparam int          HASH_BITS  = 8;

	localparam int KEY_W   = 64;
	localparam int SIDX_W  = 6;
	localparam int SLOT_W  = 6;
	localparam int OCC_W   = 7;
	localparam int IN_DW   = 136;
	localparam int OUT_DW  = 80;

	typedef enum logic [1:0] {
		CMD_ATTACH   = 2'd0,
		CMD_FIND     = 2'd1,
		CMD_COMPLETE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b0_0000_0001,
		ST_HASH  = 9'b0_0000_0010,
		ST_PROBE = 9'b0_0000_0100,
		ST_PCMP  = 9'b0_0000_1000,
		ST_CREAD = 9'b0_0001_0000,
		ST_CPAR  = 9'b0_0010_0000,
		ST_BSCAN = 9'b0_0100_0000,
		ST_BMOVE = 9'b0_1000_0000,
		ST_DONE  = 9'b1_0000_0000
	} state_t;

endpackage

// File: design/lpht_ram.sv
module lpht_ram #(
	parameter int WIDTH = 134,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/lpht_hash.sv
module lpht_hash #(
	parameter int TABLE_SLOTS = 64,
	localparam int SW = $clog2(TABLE_SLOTS)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [lpht_pkg::KEY_W-1:0] key,
	output logic                     done,
	output logic [SW-1:0]            home
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_LL   = 3'd1;
	localparam logic [2:0] PH_LH   = 3'd2;
	localparam logic [2:0] PH_HL   = 3'd3;
	localparam logic [2:0] PH_SUM  = 3'd4;
	localparam logic [2:0] PH_RED  = 3'd5;

	localparam logic [31:0] MULT_LO = lpht_pkg::HASH_MULT[31:0];
	localparam logic [31:0] MULT_HI = lpht_pkg::HASH_MULT[63:32];

	logic [2:0]  phase_q;
	logic [63:0] key_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [SW-1:0] home_q;
	logic        done_q;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [63:0] acc_add;

	// reduce the hash byte modulo the slot count by restoring subtraction
	function automatic logic [SW-1:0] reduce(input logic [lpht_pkg::HASH_BITS-1:0] x);
		logic [16:0] r;
		logic [16:0] m;
		r = 17'(x);
		for (int k = 7; k >= 0; k--) begin
			m = 17'(TABLE_SLOTS) << k;
			if (r >= m) begin
				r = r - m;
			end
		end
		return r[SW-1:0];
	endfunction

	// one 32x32 multiplier walks through the partial products of the low 64 bits
	assign mul_a   = (phase_q == PH_HL) ? key_q[63:32] : key_q[31:0];
	assign mul_b   = (phase_q == PH_LH) ? MULT_HI : MULT_LO;
	assign prod    = mul_a * mul_b;
	assign acc_add = acc_q + {prod_q[31:0], 32'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_LL;
					end
				end
				PH_LL, PH_LH, PH_HL, PH_SUM: phase_q <= phase_q + 3'd1;
				PH_RED: begin
					phase_q <= PH_IDLE;
					done_q  <= 1'b1;
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && phase_q == PH_IDLE) begin
			key_q <= key;
		end
		prod_q <= prod;
		case (phase_q)
			PH_LH:          acc_q <= prod_q;
			PH_HL, PH_SUM:  acc_q <= acc_add;
			default:        acc_q <= acc_q;
		endcase
		if (phase_q == PH_RED) begin
			home_q <= reduce(acc_q[lpht_pkg::HASH_SHIFT +: lpht_pkg::HASH_BITS]);
		end
	end

	assign done = done_q;
	assign home = home_q;

endmodule

// File: design/linear_probe_hash_table.sv
// hash table of 64-bit capability ids, open addressing with linear probing
//
// input channel s_*: one transaction per command. s_tuser carries the command
// (attach, find, complete), s_tdata the keys and the slot to free.
// output channel m_*: exactly one transaction per command, in order, with the
// status in m_tuser and slot, walker flag, parent id and occupancy in m_tdata.
//
// one command is worked at a time; s_tready is high only while idle, which
// resumes in the cycle after the result is registered.
// attach/find: hashing on the single 32x32 multiplier, then a read state and a compare
// state per occupied slot probed (the slot RAM has one read port with a registered read),
// one probe state for the empty slot that ends a miss and a done state to hand the result over.
// complete: read and done on an empty slot, else read, parent fetch, a scan and a move per
// entry scanned, a last scan and done; the worst case scales with the slot count.
//
// reset clears every slot valid bit and the live count; the table is usable
// as soon as reset is released, with no clearing pass.
// the result sits in an output register; a new command is taken while it waits,
// and if the receiver keeps stalling the next finished result is held back
// and s_tready stays low until the register frees.
module linear_probe_hash_table #(
	parameter int TABLE_SLOTS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// cap_key [63:0], parent_key [127:64], slot_index [133:128], zero [135:134]
	input  logic [135:0] s_tdata,
	// command [1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// found_slot [5:0], is_walker [6], entry_parent [70:7], occupancy [77:71], zero [79:78]
	output logic [79:0]  m_tdata,
	// status [1:0]
	output logic [1:0]   m_tuser
);

	localparam int SW = $clog2(TABLE_SLOTS);
	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam int RW = 2 * lpht_pkg::KEY_W + SW;
	localparam logic [SW-1:0] LAST  = SW'(TABLE_SLOTS - 1);
	localparam logic [CW-1:0] SLOTS = CW'(TABLE_SLOTS);
	localparam logic [TABLE_SLOTS-1:0] SLOT_ONE = TABLE_SLOTS'(1);

	lpht_pkg::state_t  state_q;
	logic [1:0]        cmd_q;
	logic [63:0]       key_q;
	logic [63:0]       parent_q;
	logic [5:0]        sidx_q;
	logic [SW-1:0]     slot_q;
	logic [SW-1:0]     hole_q;
	logic [CW-1:0]     n_q;
	logic [CW-1:0]     count_q;
	logic [TABLE_SLOTS-1:0] valid_q;

	lpht_pkg::status_t res_status_q;
	logic [5:0]        res_slot_q;
	logic              res_walker_q;
	logic [63:0]       res_parent_q;

	logic              m_tvalid_q;
	logic [79:0]       m_tdata_q;
	logic [1:0]        m_tuser_q;

	logic              s_accept;
	logic              hash_start;
	logic              hash_done;
	logic [SW-1:0]     hash_home;

	logic              ram_we;
	logic [SW-1:0]     ram_waddr;
	logic [RW-1:0]     ram_wdata;
	logic              ram_re;
	logic [SW-1:0]     ram_raddr;
	logic [RW-1:0]     rd_data;

	logic              sidx_in_range;
	logic [SW-1:0]     sidx_i;
	logic              sidx_live;
	logic [SW-1:0]     slot_next;
	logic              probe_miss;
	logic              can_insert;
	logic              scan_go;
	logic [SW-1:0]     rd_home;
	logic [SW-1:0]     d_home;
	logic [SW-1:0]     d_hole;
	logic              do_move;
	logic              out_free;

	// cyclic distance from b forward to a
	function automatic logic [SW-1:0] modsub(input logic [SW-1:0] a, input logic [SW-1:0] b);
		logic [SW:0] diff;
		diff = {1'b0, a} - {1'b0, b};
		if (diff[SW]) begin
			diff = diff + (SW+1)'(TABLE_SLOTS);
		end
		return diff[SW-1:0];
	endfunction

	assign s_accept   = s_tvalid && s_tready;
	assign s_tready   = (state_q == lpht_pkg::ST_IDLE);
	assign hash_start = s_accept &&
		(s_tuser == lpht_pkg::CMD_ATTACH || s_tuser == lpht_pkg::CMD_FIND);

	assign sidx_in_range = 9'(sidx_q) < 9'(TABLE_SLOTS);
	assign sidx_i        = SW'(sidx_q);
	assign sidx_live     = sidx_in_range ? valid_q[sidx_i] : 1'b0;
	assign slot_next     = (slot_q == LAST) ? '0 : slot_q + 1'b1;
	assign probe_miss    = (n_q == SLOTS) || !valid_q[slot_q];
	assign can_insert    = (cmd_q == lpht_pkg::CMD_ATTACH) && (count_q < SLOTS);
	assign scan_go       = (n_q != SLOTS) && valid_q[slot_q];
	assign rd_home       = rd_data[2*lpht_pkg::KEY_W +: SW];
	assign d_home        = modsub(slot_q, rd_home);
	assign d_hole        = modsub(slot_q, hole_q);
	assign do_move       = (d_home >= d_hole);
	assign out_free      = !m_tvalid_q || m_tready;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = slot_q;
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = {hash_home, parent_q, key_q};
		case (state_q)
			lpht_pkg::ST_PROBE: begin
				ram_re = !probe_miss;
				ram_we = probe_miss && can_insert;
			end
			lpht_pkg::ST_CREAD: begin
				ram_re    = sidx_live;
				ram_raddr = sidx_i;
			end
			lpht_pkg::ST_BSCAN: ram_re = scan_go;
			lpht_pkg::ST_BMOVE: begin
				ram_we    = do_move;
				ram_waddr = hole_q;
				ram_wdata = rd_data;
			end
			default: ram_re = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lpht_pkg::ST_IDLE;
			valid_q    <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == lpht_pkg::ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				lpht_pkg::ST_IDLE: begin
					if (s_accept) begin
						case (s_tuser)
							lpht_pkg::CMD_ATTACH, lpht_pkg::CMD_FIND:
								state_q <= lpht_pkg::ST_HASH;
							lpht_pkg::CMD_COMPLETE:
								state_q <= lpht_pkg::ST_CREAD;
							default: state_q <= lpht_pkg::ST_DONE;
						endcase
					end
				end
				lpht_pkg::ST_HASH: begin
					if (hash_done) begin
						state_q <= lpht_pkg::ST_PROBE;
					end
				end
				lpht_pkg::ST_PROBE: begin
					if (!probe_miss) begin
						state_q <= lpht_pkg::ST_PCMP;
					end else begin
						if (can_insert) begin
							valid_q[slot_q] <= 1'b1;
							count_q         <= count_q + 1'b1;
						end
						state_q <= lpht_pkg::ST_DONE;
					end
				end
				lpht_pkg::ST_PCMP: begin
					if (rd_data[63:0] == key_q) begin
						state_q <= lpht_pkg::ST_DONE;
					end else begin
						state_q <= lpht_pkg::ST_PROBE;
					end
				end
				lpht_pkg::ST_CREAD: begin
					state_q <= sidx_live ? lpht_pkg::ST_CPAR : lpht_pkg::ST_DONE;
				end
				lpht_pkg::ST_CPAR: begin
					valid_q[sidx_i] <= 1'b0;
					count_q         <= count_q - 1'b1;
					state_q         <= lpht_pkg::ST_BSCAN;
				end
				lpht_pkg::ST_BSCAN: begin
					state_q <= scan_go ? lpht_pkg::ST_BMOVE : lpht_pkg::ST_DONE;
				end
				lpht_pkg::ST_BMOVE: begin
					// the entry leaves its slot and fills the hole
					if (do_move) begin
						valid_q <= (valid_q | (SLOT_ONE << hole_q)) & ~(SLOT_ONE << slot_q);
					end
					state_q <= lpht_pkg::ST_BSCAN;
				end
				lpht_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= lpht_pkg::ST_IDLE;
					end
				end
				default: state_q <= lpht_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			lpht_pkg::ST_IDLE: begin
				if (s_accept) begin
					cmd_q        <= s_tuser;
					key_q        <= s_tdata[63:0];
					parent_q     <= s_tdata[127:64];
					sidx_q       <= s_tdata[133:128];
					res_status_q <= lpht_pkg::STAT_MISS;
					res_slot_q   <= '0;
					res_walker_q <= 1'b0;
					res_parent_q <= '0;
				end
			end
			lpht_pkg::ST_HASH: begin
				slot_q <= hash_home;
				n_q    <= '0;
			end
			lpht_pkg::ST_PROBE: begin
				if (probe_miss) begin
					if (can_insert) begin
						res_status_q <= lpht_pkg::STAT_OK;
						res_slot_q   <= 6'(slot_q);
						res_walker_q <= 1'b1;
						res_parent_q <= parent_q;
					end else if (cmd_q == lpht_pkg::CMD_ATTACH) begin
						res_status_q <= lpht_pkg::STAT_FULL;
					end
				end
			end
			lpht_pkg::ST_PCMP: begin
				if (rd_data[63:0] == key_q) begin
					res_status_q <= lpht_pkg::STAT_OK;
					res_slot_q   <= 6'(slot_q);
					res_parent_q <= rd_data[127:64];
				end else begin
					slot_q <= slot_next;
					n_q    <= n_q + 1'b1;
				end
			end
			lpht_pkg::ST_CREAD: begin
				res_slot_q <= sidx_q;
			end
			lpht_pkg::ST_CPAR: begin
				res_status_q <= lpht_pkg::STAT_OK;
				res_parent_q <= rd_data[127:64];
				hole_q       <= sidx_i;
				slot_q       <= (sidx_i == LAST) ? '0 : sidx_i + 1'b1;
				n_q          <= '0;
			end
			lpht_pkg::ST_BMOVE: begin
				if (do_move) begin
					hole_q <= slot_q;
				end
				slot_q <= slot_next;
				n_q    <= n_q + 1'b1;
			end
			lpht_pkg::ST_DONE: begin
				if (out_free) begin
					m_tuser_q <= res_status_q;
					m_tdata_q <= {2'b00, 7'(count_q), res_parent_q, res_walker_q, res_slot_q};
				end
			end
			default: cmd_q <= cmd_q;
		endcase
	end

	lpht_hash #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (hash_start),
		.key   (s_tdata[63:0]),
		.done  (hash_done),
		.home  (hash_home)
	);

	lpht_ram #(
		.WIDTH(RW),
		.DEPTH(TABLE_SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// File: design/lpht_checker.sv
module lpht_checker #(
	parameter int TABLE_SLOTS = 64
) (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [79:0]  m_tdata,
	input logic [1:0]   m_tuser
);

	// one command in flight: the input side closes right after a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a command is in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[77:71] <= 7'(TABLE_SLOTS))
		else $error("occupancy above slot count");

	// a fresh insert always reports ok
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6] |-> m_tuser == lpht_pkg::STAT_OK)
		else $error("walker flag without ok status");

	// full only when every slot is live, with a cleared slot field
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == lpht_pkg::STAT_FULL |->
			m_tdata[77:71] == 7'(TABLE_SLOTS) && m_tdata[5:0] == 6'd0)
		else $error("full status on a table with room");

endmodule

bind linear_probe_hash_table lpht_checker #(
	.TABLE_SLOTS(TABLE_SLOTS)
) u_lpht_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
